FILE: hdl/ffsc_pkg.sv
// ----------------------------------------------------------------------------
// ffsc_pkg
// Shared types and constants of the frame flash / scene cut classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsc_pkg;

  localparam int MAX_PIXELS = 65536;

  localparam int PIX_W   = 16;
  localparam int LUMA_W  = 8;
  localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
  localparam int RATIO_W = 17;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  localparam logic [RATIO_W-1:0] FLASH_RATIO_RESET = RATIO_W'(58982);
  localparam logic [RATIO_W-1:0] CUT_RATIO_RESET   = RATIO_W'(49152);

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FLASH_RATIO = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CUT_RATIO   = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_FLASH = 2'd1,
    VERDICT_CUT   = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [CNT_W-1:0] changed;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] steps;
    logic [CNT_W-1:0] same;
  } frame_stats_t;

endpackage

`default_nettype wire

FILE: hdl/ffsc_luma.sv
// ----------------------------------------------------------------------------
// ffsc_luma
// RGB565 pixel to 8-bit luma: channel expansion to 8 bits, weights
// 54/183/19, then a right shift by 8.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsc_luma (
  input  wire logic [ffsc_pkg::PIX_W-1:0]  pixel,
  output logic      [ffsc_pkg::LUMA_W-1:0] luma
);
  import ffsc_pkg::*;

  localparam logic [15:0] W_RED   = 16'd54;
  localparam logic [15:0] W_GREEN = 16'd183;
  localparam logic [15:0] W_BLUE  = 16'd19;

  // floor(r*255/31) = 8r + floor(7r/31)
  function automatic logic [7:0] expand5(input logic [4:0] r);
    logic [7:0] e;
    e = {r, 3'b000};
    e = e + {7'b0, r >= 5'd5} + {7'b0, r >= 5'd9} + {7'b0, r >= 5'd14}
          + {7'b0, r >= 5'd18} + {7'b0, r >= 5'd23} + {7'b0, r >= 5'd27}
          + {7'b0, r >= 5'd31};
    return e;
  endfunction

  // floor(g*255/63) = 4g + floor(g/21)
  function automatic logic [7:0] expand6(input logic [5:0] g);
    logic [7:0] e;
    e = {g, 2'b00};
    e = e + {7'b0, g >= 6'd21} + {7'b0, g >= 6'd42} + {7'b0, g >= 6'd63};
    return e;
  endfunction

  logic [7:0]  red8;
  logic [7:0]  green8;
  logic [7:0]  blue8;
  logic [15:0] weighted;

  assign red8   = expand5(pixel[15:11]);
  assign green8 = expand6(pixel[10:5]);
  assign blue8  = expand5(pixel[4:0]);

  // peaks at 256*255, fits 16 bits
  assign weighted = 16'(red8) * W_RED + 16'(green8) * W_GREEN + 16'(blue8) * W_BLUE;
  assign luma     = weighted[15:8];

endmodule

`default_nettype wire

FILE: hdl/frame_flash_scene_cut_classifier.sv
// ----------------------------------------------------------------------------
// frame_flash_scene_cut_classifier
// Counts changed, large-step and same-sign pixel pairs over a frame and
// gives a flash / scene cut verdict on the last pair.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------------
//  input     in         in_valid / in_stall  pixel_prev, pixel_next, frame_end
//  result    out        out_valid/out_stall  verdict, changed_count, total_count
//  config    in         cfg_write            cfg_index, cfg_data
//
//  one pixel pair is taken per clock while in_stall is low; the verdict of a frame
//  passes through the stages below to the result register after its last pair is taken.
//  stages: input register, luma register, counter update, product register,
//  result register; only a frame-end item in the counter stage waits on a
//  stalled result, other pairs keep flowing.
//  rst clears all counters, the latched sign and the valid bits, and loads
//  the ratio thresholds with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_flash_scene_cut_classifier (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [ffsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ffsc_pkg::RATIO_W-1:0]     cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ffsc_pkg::PIX_W-1:0]       pixel_prev,
  input  wire logic [ffsc_pkg::PIX_W-1:0]       pixel_next,
  input  wire logic                             frame_end,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [1:0]                       verdict,
  output logic      [ffsc_pkg::CNT_W-1:0]       changed_count,
  output logic      [ffsc_pkg::CNT_W-1:0]       total_count
);
  import ffsc_pkg::*;

  localparam int PROD_W  = RATIO_W + CNT_W;
  localparam int SCALE_W = CNT_W + 4;
  localparam logic [LUMA_W:0] LARGE_STEP = (LUMA_W+1)'(96);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < CNT_MAX) ? v + CNT_W'(1) : CNT_MAX;
  endfunction

  // configuration
  logic [RATIO_W-1:0] flash_ratio;
  logic [RATIO_W-1:0] cut_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_ratio <= FLASH_RATIO_RESET;
      cut_ratio   <= CUT_RATIO_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FLASH_RATIO: flash_ratio <= cfg_data;
        REG_CUT_RATIO:   cut_ratio   <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic out_load, s4_take, s3_take, s2_go, s2_take, s1_take;
  logic s2_last;

  assign out_load = !out_valid || !out_stall;
  assign s4_take  = !s4_valid || out_load;
  assign s3_take  = !s3_valid || s4_take;
  assign s2_go    = s2_valid && (!s2_last || s3_take);
  assign s2_take  = !s2_valid || s2_go;
  assign s1_take  = !s1_valid || s2_take;
  assign in_stall = !s1_take;

  // input register
  logic [PIX_W-1:0] s1_prev;
  logic [PIX_W-1:0] s1_next;
  logic             s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_take) begin
      s1_prev <= pixel_prev;
      s1_next <= pixel_next;
      s1_last <= frame_end;
    end
  end

  // luma register
  logic [LUMA_W-1:0] luma_prev, luma_next;
  logic [LUMA_W-1:0] s2_luma_prev, s2_luma_next;
  logic              s2_diff;

  ffsc_luma u_luma_prev (.pixel(s1_prev), .luma(luma_prev));
  ffsc_luma u_luma_next (.pixel(s1_next), .luma(luma_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_take) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_take) begin
      s2_luma_prev <= luma_prev;
      s2_luma_next <= luma_next;
      s2_diff      <= (s1_prev != s1_next);
      s2_last      <= s1_last;
    end
  end

  // counter update
  logic [CNT_W-1:0] pair_cnt, changed_cnt, large_cnt, same_cnt;
  logic [CNT_W-1:0] pair_cnt_next, changed_cnt_next, large_cnt_next, same_cnt_next;
  sign_t            first_sign, first_sign_next;
  logic [LUMA_W:0]  delta;
  logic [LUMA_W:0]  delta_mag;
  sign_t            delta_sign;
  frame_stats_t     s3_stats;

  always_comb begin
    delta      = {1'b0, s2_luma_next} - {1'b0, s2_luma_prev};
    delta_mag  = delta[LUMA_W] ? (~delta + (LUMA_W+1)'(1)) : delta;
    delta_sign = (delta == '0) ? SIGN_NONE : (delta[LUMA_W] ? SIGN_NEG : SIGN_POS);

    pair_cnt_next    = sat_inc(pair_cnt);
    changed_cnt_next = changed_cnt;
    large_cnt_next   = large_cnt;
    same_cnt_next    = same_cnt;
    first_sign_next  = first_sign;
    if (s2_diff) begin
      changed_cnt_next = sat_inc(changed_cnt);
      if (delta_mag >= LARGE_STEP) begin
        large_cnt_next = sat_inc(large_cnt);
      end
      if (first_sign == SIGN_NONE) begin
        first_sign_next = delta_sign;
      end
      if (delta_sign != SIGN_NONE && delta_sign == first_sign_next) begin
        same_cnt_next = sat_inc(same_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_cnt    <= '0;
      changed_cnt <= '0;
      large_cnt   <= '0;
      same_cnt    <= '0;
      first_sign  <= SIGN_NONE;
    end else if (s2_go) begin
      if (s2_last) begin
        pair_cnt    <= '0;
        changed_cnt <= '0;
        large_cnt   <= '0;
        same_cnt    <= '0;
        first_sign  <= SIGN_NONE;
      end else begin
        pair_cnt    <= pair_cnt_next;
        changed_cnt <= changed_cnt_next;
        large_cnt   <= large_cnt_next;
        same_cnt    <= same_cnt_next;
        first_sign  <= first_sign_next;
      end
    end
  end

  // frame totals, taken on the last pair
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_take) begin
      s3_valid <= s2_go && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_last) begin
      s3_stats.changed <= changed_cnt_next;
      s3_stats.total   <= pair_cnt_next;
      s3_stats.steps   <= large_cnt_next;
      s3_stats.same    <= same_cnt_next;
    end
  end

  // product register
  logic [PROD_W-1:0]  s4_changed_sh, s4_flash_prod, s4_cut_prod;
  logic [SCALE_W-1:0] s4_large10, s4_same10, s4_changed9;
  logic [CNT_W-1:0]   s4_changed, s4_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_take) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s4_take) begin
      s4_changed_sh <= PROD_W'({s3_stats.changed, 16'b0});
      s4_flash_prod <= PROD_W'(flash_ratio) * PROD_W'(s3_stats.total);
      s4_cut_prod   <= PROD_W'(cut_ratio) * PROD_W'(s3_stats.total);
      s4_large10    <= SCALE_W'(s3_stats.steps) * SCALE_W'(10);
      s4_same10     <= SCALE_W'(s3_stats.same) * SCALE_W'(10);
      s4_changed9   <= SCALE_W'(s3_stats.changed) * SCALE_W'(9);
      s4_changed    <= s3_stats.changed;
      s4_total      <= s3_stats.total;
    end
  end

  // verdict and result register
  verdict_t verdict_next;

  always_comb begin
    verdict_next = VERDICT_NONE;
    if (s4_changed_sh >= s4_flash_prod && s4_large10 >= s4_changed9
        && s4_same10 >= s4_changed9) begin
      verdict_next = VERDICT_FLASH;
    end else if (s4_changed_sh >= s4_cut_prod) begin
      verdict_next = VERDICT_CUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid && out_load) begin
      verdict       <= verdict_next;
      changed_count <= s4_changed;
      total_count   <= s4_total;
    end
  end

`ifndef SYNTHESIS
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    changed_cnt <= pair_cnt && large_cnt <= changed_cnt && same_cnt <= changed_cnt)
    else $error("frame counters out of order");

  a_same_needs_sign: assert property (@(posedge clk) disable iff (rst)
    first_sign == SIGN_NONE |-> same_cnt == '0)
    else $error("same-sign count without a latched sign");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    s2_go && s2_last |=> pair_cnt == '0 && first_sign == SIGN_NONE)
    else $error("state not cleared after frame end");

  a_totals_nonzero: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> s3_stats.total != '0)
    else $error("frame totals with no pairs");
`endif

endmodule

`default_nettype wire
